### hdl/mlf_pkg.sv
// Shared types, constants and saturation helper of the four-pole ladder low-pass filter.
`default_nettype none

package mlf_pkg;

	// Item opcodes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 1'd1;
	localparam logic [15:0] CUTOFF_RESET    = 16'd26214;
	localparam logic [15:0] RESONANCE_RESET = 16'd14746;

	// Q4.20 constants.
	localparam logic signed [23:0] K_ONE   = 24'sd1048576;
	localparam logic signed [23:0] K_OLD   = 24'sd943718;
	localparam logic signed [23:0] K_NEW   = 24'sd104858;
	localparam logic signed [23:0] K_P08   = 24'sd838861;
	localparam logic signed [23:0] K_Q56   = 24'sd5872026;
	localparam logic signed [23:0] K_HALF  = 24'sd524288;
	localparam logic signed [23:0] K_SIXTH = 24'sd174763;

	// Saturation modes.
	localparam logic [1:0] SAT_NONE = 2'd0;
	localparam logic [1:0] SAT_24   = 2'd1;
	localparam logic [1:0] SAT_32   = 2'd2;

	// Sequencer step kinds.
	localparam logic [1:0] KIND_MUL = 2'd0;
	localparam logic [1:0] KIND_FIN = 2'd1;
	localparam logic [1:0] KIND_OUT = 2'd2;

	// Accumulator operations.
	localparam logic [1:0] ACC_LOAD = 2'd0;
	localparam logic [1:0] ACC_ADD  = 2'd1;
	localparam logic [1:0] ACC_SUB  = 2'd2;

	// Destinations of a finishing step.
	localparam logic [3:0] DST_NONE = 4'd0;
	localparam logic [3:0] DST_SC   = 4'd1;
	localparam logic [3:0] DST_SR   = 4'd2;
	localparam logic [3:0] DST_P    = 4'd3;
	localparam logic [3:0] DST_F    = 4'd4;
	localparam logic [3:0] DST_Q    = 4'd5;
	localparam logic [3:0] DST_U    = 4'd6;
	localparam logic [3:0] DST_W    = 4'd7;
	localparam logic [3:0] DST_T    = 4'd8;
	localparam logic [3:0] DST_ST   = 4'd9;

	// Decoded control of one sequencer step.
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] acc_op;
		logic       sh27;
		logic [1:0] isat;
		logic [1:0] osat;
		logic       neg;
		logic       use_acc;
		logic [3:0] dest;
		logic [2:0] didx;
		logic       last;
	} ctrl_t;

	// Clamp a wide signed value to a 24-bit or 32-bit signed range, or pass it through unchanged.
	function automatic logic signed [67:0] sat68(input logic signed [67:0] v,
		input logic [1:0] mode);
		logic signed [67:0] hi;
		logic signed [67:0] lo;
		logic signed [67:0] r;
		hi = 68'sd0;
		lo = 68'sd0;
		r  = v;
		unique case (mode)
			SAT_24: begin
				hi = 68'sd8388607;
				lo = -68'sd8388608;
			end
			SAT_32: begin
				hi = 68'sd2147483647;
				lo = -68'sd2147483648;
			end
			default: begin
				hi = v;
				lo = v;
			end
		endcase
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/mlf_if.sv
// Valid/ready channel interfaces for input items and result words of the ladder filter.
`default_nettype none

interface mlf_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [23:0] sample_in;

	modport source (output valid, output op, output sample_in, input ready);
	modport sink (input valid, input op, input sample_in, output ready);
endinterface

interface mlf_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### hdl/moog_ladder_lowpass_filter.sv
// Top level of the four-pole ladder low-pass filter with its shared multiply-accumulate unit.
`default_nettype none

// Four-pole ladder low-pass filter in fixed point. Each input word carries an opcode: a sample
// word (op 0) runs one Q1.23 sample through feedback, four one-pole stages and cubic soft
// clipping and returns one Q1.23 result word; an update word (op 1) moves the smoothed cutoff
// and resonance toward the configuration registers and recomputes the coefficients p, f and q,
// returning nothing. All arithmetic runs through a single 33 x 32 bit signed multiplier with a
// 66-bit accumulator, followed by one round, saturate and add stage, all stepped by a small
// sequencer. The input is ready only while the sequencer is idle, so a new word is accepted only
// once the last one is through. A sample word takes twelve multiplications and one finishing
// step for every rounded and stored value (eight) plus one more to load the result register; an
// update word takes eleven multiplications and eleven finishing steps for its stored values.
// A finished result sits in an output register, so the next word is accepted while it waits;
// only when a second result is ready before the first is taken does the sequencer hold.
// The configuration port writes cutoff (index 0) and resonance_target (index 1) and should
// only be used while the block is idle.
module moog_ladder_lowpass_filter
	import mlf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mlf_in_if.sink                    samples,
	mlf_out_if.source                 results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	// Step numbers of the final step of each sequence.
	localparam logic [4:0] LAST_SMP = 5'd20;
	localparam logic [4:0] LAST_UPD = 5'd21;

	localparam logic signed [67:0] HALF20 = 68'sd524288;
	localparam logic signed [67:0] HALF27 = 68'sd67108864;
	localparam logic signed [67:0] HALF4  = 68'sd8;

	// Configuration registers.
	logic [15:0] cutoff_q;
	logic [15:0] res_target_q;

	// Filter state: smoothed values, coefficients and the five stage values.
	logic signed [23:0] sc_q;
	logic signed [23:0] sr_q;
	logic signed [23:0] p_q;
	logic signed [23:0] f_q;
	logic signed [23:0] q_q;
	logic signed [31:0] st_q [5];

	// Sequencer and working registers.
	logic               busy_q;
	logic               op_q;
	logic [4:0]         step_q;
	logic signed [23:0] x_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] old_q;
	logic signed [31:0] t_q;
	logic signed [23:0] u_q;
	logic signed [23:0] w_q;

	// Output register.
	logic               out_valid_q;
	logic signed [23:0] out_data_q;

	ctrl_t              ctrl;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [67:0] base;
	logic signed [64:0] prod;
	logic signed [65:0] acc_next;
	logic signed [67:0] acc_x;
	logic signed [67:0] rnd;
	logic signed [67:0] term_raw;
	logic signed [67:0] term;
	logic signed [67:0] fin_sum;
	logic signed [67:0] fin_res68;
	logic signed [31:0] fin_res;
	logic signed [67:0] y68;
	logic               out_load;

	assign samples.ready      = !busy_q;
	assign results.valid      = out_valid_q;
	assign results.sample_out = out_data_q;

	// Step decode. Multiply steps choose the operands and the accumulator operation; finishing
	// steps round and clamp the accumulator if used, add a base value, clamp again and store the result.
	always_comb begin
		ctrl    = '{kind: KIND_FIN, acc_op: ACC_LOAD, sh27: 1'b0, isat: SAT_NONE, osat: SAT_32,
			neg: 1'b0, use_acc: 1'b1, dest: DST_NONE, didx: 3'd0, last: 1'b0};
		mul_a   = 33'sd0;
		mul_b   = 32'sd0;
		base    = 68'sd0;
		if (op_q == OP_UPDATE) begin
			ctrl.osat = SAT_24;
			case (step_q)
				// Smooth the cutoff toward its register.
				5'd0: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(sc_q);
					mul_b     = 32'(K_OLD);
				end
				5'd1: begin
					ctrl.kind   = KIND_MUL;
					ctrl.acc_op = ACC_ADD;
					mul_a       = $signed({13'd0, cutoff_q, 4'd0});
					mul_b       = 32'(K_NEW);
				end
				5'd2: ctrl.dest = DST_SC;
				// Smooth the resonance toward its register.
				5'd3: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(sr_q);
					mul_b     = 32'(K_OLD);
				end
				5'd4: begin
					ctrl.kind   = KIND_MUL;
					ctrl.acc_op = ACC_ADD;
					mul_a       = $signed({11'd0, res_target_q, 6'd0});
					mul_b       = 32'(K_NEW);
				end
				5'd5: ctrl.dest = DST_SR;
				// u = 1 - fr
				5'd6: begin
					ctrl.use_acc = 1'b0;
					base         = 68'(K_ONE) - 68'(sc_q);
					ctrl.dest    = DST_U;
				end
				// p = fr + (0.8 * fr) * u
				5'd7: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(K_P08);
					mul_b     = 32'(sc_q);
				end
				5'd8: ctrl.dest = DST_T;
				5'd9: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(t_q);
					mul_b     = 32'(u_q);
				end
				5'd10: begin
					ctrl.isat = SAT_24;
					base      = 68'(sc_q);
					ctrl.dest = DST_P;
				end
				// f = 2p - 1
				5'd11: begin
					ctrl.use_acc = 1'b0;
					base         = 68'(p_q) + 68'(p_q) - 68'(K_ONE);
					ctrl.dest    = DST_F;
				end
				// inner = 1 - u + (5.6 * u) * u
				5'd12: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(K_Q56);
					mul_b     = 32'(u_q);
				end
				5'd13: ctrl.dest = DST_T;
				5'd14: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(t_q);
					mul_b     = 32'(u_q);
				end
				5'd15: begin
					ctrl.isat = SAT_24;
					base      = 68'(K_ONE) - 68'(u_q);
					ctrl.dest = DST_W;
				end
				// outer = 1 + (0.5 * u) * inner
				5'd16: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(K_HALF);
					mul_b     = 32'(u_q);
				end
				5'd17: ctrl.dest = DST_T;
				5'd18: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(t_q);
					mul_b     = 32'(w_q);
				end
				5'd19: begin
					ctrl.isat = SAT_24;
					base      = 68'(K_ONE);
					ctrl.dest = DST_W;
				end
				// q = r * outer
				5'd20: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(sr_q);
					mul_b     = 32'(w_q);
				end
				5'd21: begin
					ctrl.dest = DST_Q;
					ctrl.last = 1'b1;
				end
				default: ctrl.kind = KIND_FIN;
			endcase
		end else begin
			case (step_q)
				// Feedback: in = x - q * b4, stored as the new stage 0 value.
				5'd0: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(q_q);
					mul_b     = st_q[4];
				end
				5'd1: begin
					base      = 68'(x_q) <<< 4;
					ctrl.neg  = 1'b1;
					ctrl.dest = DST_ST;
					ctrl.didx = 3'd0;
				end
				// Pole 1.
				5'd2: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(st_q[0]) + 33'(old_q);
					mul_b     = 32'(p_q);
				end
				5'd3: begin
					ctrl.kind   = KIND_MUL;
					ctrl.acc_op = ACC_SUB;
					mul_a       = 33'(st_q[1]);
					mul_b       = 32'(f_q);
				end
				5'd4: begin
					ctrl.dest = DST_ST;
					ctrl.didx = 3'd1;
				end
				// Pole 2.
				5'd5: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(st_q[1]) + 33'(old_q);
					mul_b     = 32'(p_q);
				end
				5'd6: begin
					ctrl.kind   = KIND_MUL;
					ctrl.acc_op = ACC_SUB;
					mul_a       = 33'(st_q[2]);
					mul_b       = 32'(f_q);
				end
				5'd7: begin
					ctrl.dest = DST_ST;
					ctrl.didx = 3'd2;
				end
				// Pole 3.
				5'd8: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(st_q[2]) + 33'(old_q);
					mul_b     = 32'(p_q);
				end
				5'd9: begin
					ctrl.kind   = KIND_MUL;
					ctrl.acc_op = ACC_SUB;
					mul_a       = 33'(st_q[3]);
					mul_b       = 32'(f_q);
				end
				5'd10: begin
					ctrl.dest = DST_ST;
					ctrl.didx = 3'd3;
				end
				// Pole 4.
				5'd11: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(st_q[3]) + 33'(old_q);
					mul_b     = 32'(p_q);
				end
				5'd12: begin
					ctrl.kind   = KIND_MUL;
					ctrl.acc_op = ACC_SUB;
					mul_a       = 33'(st_q[4]);
					mul_b       = 32'(f_q);
				end
				5'd13: begin
					ctrl.dest = DST_ST;
					ctrl.didx = 3'd4;
				end
				// Soft clip: b4 - b4^3 / 6.
				5'd14: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(st_q[4]);
					mul_b     = st_q[4];
				end
				5'd15: begin
					ctrl.sh27 = 1'b1;
					ctrl.dest = DST_T;
				end
				5'd16: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(t_q);
					mul_b     = st_q[4];
				end
				5'd17: begin
					ctrl.sh27 = 1'b1;
					ctrl.dest = DST_T;
				end
				5'd18: begin
					ctrl.kind = KIND_MUL;
					mul_a     = 33'(t_q);
					mul_b     = 32'(K_SIXTH);
				end
				5'd19: begin
					ctrl.isat = SAT_32;
					base      = 68'(st_q[4]);
					ctrl.neg  = 1'b1;
					ctrl.dest = DST_ST;
					ctrl.didx = 3'd4;
				end
				5'd20: begin
					ctrl.kind = KIND_OUT;
					ctrl.last = 1'b1;
				end
				default: ctrl.kind = KIND_FIN;
			endcase
		end
	end

	// Shared multiplier and accumulator.
	assign prod = 65'(mul_a) * 65'(mul_b);

	always_comb begin
		unique case (ctrl.acc_op)
			ACC_ADD: acc_next = acc_q + 66'(prod);
			ACC_SUB: acc_next = acc_q - 66'(prod);
			default: acc_next = 66'(prod);
		endcase
	end

	// Finishing stage: round half up, clamp, add the base value and clamp again.
	assign acc_x     = 68'(acc_q);
	assign rnd       = ctrl.sh27 ? ((acc_x + HALF27) >>> 27) : ((acc_x + HALF20) >>> 20);
	assign term_raw  = ctrl.use_acc ? sat68(rnd, ctrl.isat) : 68'sd0;
	assign term      = ctrl.neg ? -term_raw : term_raw;
	assign fin_sum   = base + term;
	assign fin_res68 = sat68(fin_sum, ctrl.osat);
	assign fin_res   = fin_res68[31:0];

	// Output sample: last stage rounded from Q5.27 to Q1.23.
	assign y68 = sat68((68'(st_q[4]) + HALF4) >>> 4, SAT_24);

	// The result register takes a new word when it is empty or its word leaves in this cycle.
	assign out_load = busy_q && (ctrl.kind == KIND_OUT) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q     <= CUTOFF_RESET;
			res_target_q <= RESONANCE_RESET;
			sc_q         <= '0;
			sr_q         <= '0;
			p_q          <= '0;
			f_q          <= -K_ONE;
			q_q          <= '0;
			for (int i = 0; i < 5; i++) begin
				st_q[i] <= '0;
			end
			busy_q       <= 1'b0;
			op_q         <= OP_SAMPLE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CUTOFF:    cutoff_q     <= cfg_data;
					REG_RESONANCE: res_target_q <= cfg_data;
					default:       cutoff_q     <= cutoff_q;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (!busy_q) begin
				if (samples.valid) begin
					busy_q <= 1'b1;
					op_q   <= samples.op;
					step_q <= '0;
				end
			end else begin
				unique case (ctrl.kind)
					KIND_MUL: begin
						step_q <= step_q + 5'd1;
					end
					KIND_OUT: begin
						// Hold here only while an earlier result word is still waiting.
						if (out_load) begin
							busy_q <= 1'b0;
							step_q <= '0;
						end
					end
					default: begin
						unique case (ctrl.dest)
							DST_SC: sc_q <= fin_res[23:0];
							DST_SR: sr_q <= fin_res[23:0];
							DST_P:  p_q  <= fin_res[23:0];
							DST_F:  f_q  <= fin_res[23:0];
							DST_Q:  q_q  <= fin_res[23:0];
							DST_ST: st_q[ctrl.didx] <= fin_res;
							default: sc_q <= sc_q;
						endcase
						if (ctrl.last) begin
							busy_q <= 1'b0;
							step_q <= '0;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				endcase
			end
		end
	end

	// Working registers without reset.
	always_ff @(posedge clk) begin
		if (!busy_q && samples.valid) begin
			x_q <= samples.sample_in;
		end
		if (busy_q && ctrl.kind == KIND_MUL) begin
			acc_q <= acc_next;
		end
		if (busy_q && ctrl.kind == KIND_FIN) begin
			unique case (ctrl.dest)
				DST_U:  u_q   <= fin_res[23:0];
				DST_W:  w_q   <= fin_res[23:0];
				DST_T:  t_q   <= fin_res;
				DST_ST: old_q <= st_q[ctrl.didx];
				default: t_q  <= t_q;
			endcase
		end
		if (out_load) begin
			out_data_q <= y68[23:0];
		end
	end

	// The step counter rests at zero whenever the sequencer is idle.
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> step_q == 5'd0)
		else $error("step counter not cleared while idle");

	// The step counter never runs past the final step of the running sequence.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (op_q ? (step_q <= LAST_UPD) : (step_q <= LAST_SMP)))
		else $error("step counter beyond the end of its sequence");

	// A new result word only comes from a sample word that was being processed.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(busy_q) && ($past(op_q) == OP_SAMPLE)))
		else $error("result word raised without a sample in progress");

	// The last stage value only changes while a word is being processed.
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> $stable(st_q[4]))
		else $error("stage value changed while idle");

endmodule

`default_nettype wire
